/* src/sha256_pkg.sv */
// sha-256 digest engine: shared types, constants and round functions
package sha256_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSORB,
        S_PAD,
        S_LENGTH,
        S_COMPRESS,
        S_FOLD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD,
        PH_LEN
    } t_phase;

    localparam int WORD_W    = 32;
    localparam int LEN_W     = 61;
    localparam int NUM_H     = 8;
    localparam int NUM_W     = 16;
    localparam int NUM_ROUND = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [WORD_W-1:0] H_INIT [0:NUM_H-1] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [0:NUM_ROUND-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                               input int s);
        return (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] v);
        return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] v);
        return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] v);
        return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] v);
        return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

/* src/sha256_message_digest.sv */
// sha-256 digest engine: top level with byte packer, padder and round sequencer
//
// Input channel (i_valid / o_ready) takes one message word: up to four bytes,
// first byte in bits 31..24, with i_byte_count valid bytes and i_last_word on
// the final word. A last word with zero bytes closes the message (empty message
// when nothing came before). Output channel (o_valid / i_ready) gives the eight
// digest words, index 0 first, o_last_of_digest on index 7.
// One word is taken at a time; o_ready is high only while idle. A full,
// aligned word is stored whole; other words are merged in byte by byte.
// Each completed 64-byte block runs 64 rounds of the single round unit and
// then folds the working variables into the chaining value.
// On a last word a padding step is followed by one or two compressions,
// then the digest words follow, one per cycle at best.
// The output holds while i_ready is low; no new word is taken until the
// eighth digest word has been taken. Afterwards the chaining value and the
// length are back at their initial values for the next message.
// Reset (synchronous, active low) restores the initial hash values, clears
// the byte count and returns to idle; no clearing pass is needed.
module sha256_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_of_digest
);
    import sha256_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_phase            r_phase;
    logic [WORD_W-1:0] r_h [0:NUM_H-1];
    logic [WORD_W-1:0] r_v [0:NUM_H-1];
    logic [WORD_W-1:0] r_w [0:NUM_W-1];
    logic [LEN_W-1:0]  r_len;
    logic [5:0]        r_round;
    logic [WORD_W-1:0] r_data;
    logic [2:0]        r_cnt;
    logic              r_last;
    logic [2:0]        r_oidx;

    logic [5:0]        pos;
    logic [3:0]        widx;
    logic [1:0]        lane;
    logic              word_fast;
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;
    logic [WORD_W-1:0] ch;
    logic [WORD_W-1:0] maj;
    logic [WORD_W-1:0] w_new;
    logic [WORD_W-1:0] ins_word;
    logic [WORD_W-1:0] pad_word;
    logic [WORD_W-1:0] len_hi;
    logic [WORD_W-1:0] len_lo;

    assign pos       = r_len[5:0];
    assign widx      = pos[5:2];
    assign lane      = pos[1:0];
    assign word_fast = (lane == 2'd0) && (r_cnt == 3'd4);
    assign len_hi    = r_len[LEN_W-1:LEN_W-32];
    assign len_lo    = {r_len[LEN_W-33:0], 3'b000};

    // byte merge into the partly filled word
    always_comb begin
        if (lane == 2'd0) begin
            ins_word = {r_data[31:24], 24'h0};
            pad_word = {PAD_BYTE, 24'h0};
        end else begin
            ins_word = r_w[widx] | ({r_data[31:24], 24'h0} >> {lane, 3'b000});
            pad_word = r_w[widx] | ({PAD_BYTE, 24'h0} >> {lane, 3'b000});
        end
    end

    // round unit
    always_comb begin
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_sigma1(r_v[4]) + ch + ROUND_K[r_round] + r_w[0];
        t2    = big_sigma0(r_v[0]) + maj;
        w_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_ABSORB;
                end
            end
            S_ABSORB: begin
                if (r_cnt == 3'd0) begin
                    n_state = r_last ? S_PAD : S_IDLE;
                end else if (word_fast) begin
                    if (pos == 6'd60) begin
                        n_state = S_COMPRESS;
                    end
                end else if (pos == 6'd63) begin
                    n_state = S_COMPRESS;
                end
            end
            S_PAD:    n_state = S_COMPRESS;
            S_LENGTH: n_state = S_COMPRESS;
            S_COMPRESS: begin
                if (r_round == 6'(NUM_ROUND - 1)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                unique case (r_phase)
                    PH_DATA: n_state = S_ABSORB;
                    PH_PAD:  n_state = S_LENGTH;
                    PH_LEN:  n_state = S_OUT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (i_ready && r_oidx == 3'(NUM_H - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DATA;
            r_len   <= '0;
            r_round <= '0;
            r_oidx  <= '0;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            for (int i = 0; i < NUM_H; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_data <= i_data_word;
                        r_cnt  <= (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
                        r_last <= i_last_word;
                    end
                end
                S_ABSORB: begin
                    r_phase <= PH_DATA;
                    if (r_cnt != 3'd0) begin
                        if (word_fast) begin
                            r_w[widx] <= r_data;
                            r_len     <= r_len + LEN_W'(4);
                            r_cnt     <= 3'd0;
                        end else begin
                            r_w[widx] <= ins_word;
                            r_len     <= r_len + LEN_W'(1);
                            r_cnt     <= r_cnt - 3'd1;
                            r_data    <= {r_data[23:0], 8'h00};
                        end
                    end
                end
                S_PAD: begin
                    r_w[widx] <= pad_word;
                    for (int i = 0; i < NUM_W; i++) begin
                        if (4'(i) > widx) begin
                            if (pos < 6'd56 && i == NUM_W - 2) begin
                                r_w[i] <= len_hi;
                            end else if (pos < 6'd56 && i == NUM_W - 1) begin
                                r_w[i] <= len_lo;
                            end else begin
                                r_w[i] <= '0;
                            end
                        end
                    end
                    if (pos >= 6'd56) begin
                        r_phase <= PH_PAD;
                    end else begin
                        r_phase <= PH_LEN;
                    end
                end
                S_LENGTH: begin
                    r_phase <= PH_LEN;
                    for (int i = 0; i < NUM_W - 2; i++) begin
                        r_w[i] <= '0;
                    end
                    r_w[NUM_W - 2] <= len_hi;
                    r_w[NUM_W - 1] <= len_lo;
                end
                S_COMPRESS: begin
                    r_round <= r_round + 6'd1;
                    r_v[0]  <= t1 + t2;
                    r_v[1]  <= r_v[0];
                    r_v[2]  <= r_v[1];
                    r_v[3]  <= r_v[2];
                    r_v[4]  <= r_v[3] + t1;
                    r_v[5]  <= r_v[4];
                    r_v[6]  <= r_v[5];
                    r_v[7]  <= r_v[6];
                    for (int i = 0; i < NUM_W - 1; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    r_w[NUM_W - 1] <= w_new;
                end
                S_FOLD: begin
                    for (int i = 0; i < NUM_H; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (r_phase == PH_LEN) begin
                        r_len <= '0;
                    end
                end
                S_OUT: begin
                    // shift the digest out, refilling with the initial values
                    if (i_ready) begin
                        for (int i = 0; i < NUM_H - 1; i++) begin
                            r_h[i] <= r_h[i + 1];
                        end
                        r_h[NUM_H - 1] <= H_INIT[r_oidx];
                        r_oidx         <= r_oidx + 3'd1;
                    end
                end
                default: begin
                    r_round <= '0;
                end
            endcase
            if (n_state == S_COMPRESS && r_state != S_COMPRESS) begin
                r_round <= '0;
                for (int i = 0; i < NUM_H; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_digest_word    = r_h[0];
    assign o_word_index     = r_oidx;
    assign o_last_of_digest = (r_oidx == 3'(NUM_H - 1));

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input and output sides active together");

    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPRESS && $past(r_state) != S_COMPRESS) |-> r_round == 6'd0)
        else $error("compression started mid-round");

    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_of_digest)
            |=> (r_len == '0 && r_h[0] == H_INIT[0] && r_oidx == 3'd0))
        else $error("state not restored after digest");

    a_fold_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> ($past(r_state) == S_COMPRESS && r_round == 6'd0))
        else $error("fold without a full set of rounds");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ABSORB) |-> r_cnt <= 3'd4)
        else $error("byte count out of range");

endmodule
